// ===== rtl/swss_pkg.sv =====
`timescale 1ns / 1ps

package swss_pkg;

  localparam int unsigned NumDigits = 4;
  localparam int unsigned PosW      = $clog2(NumDigits);
  localparam int unsigned TimeW     = 32;
  localparam int unsigned CfgW      = 16;
  localparam int unsigned SegW      = 8;

  localparam logic [3:0] DigitMax = 4'd9;

  localparam logic [CfgW-1:0] LockoutRst     = 16'd500;
  localparam logic [CfgW-1:0] CountPeriodRst = 16'd100;
  localparam logic [CfgW-1:0] BlinkPeriodRst = 16'd1000;

  typedef enum logic [1:0] {
    REG_LOCKOUT      = 2'd0,
    REG_COUNT_PERIOD = 2'd1,
    REG_BLINK_PERIOD = 2'd2,
    REG_NONE         = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic en;
    logic clear;
    logic load;
  } cell_ctl_t;

  function automatic logic [SegW-1:0] seg_lookup(input logic [3:0] digit);
    logic [SegW-1:0] seg;
    case (digit)
      4'd0:    seg = 8'hC0;
      4'd1:    seg = 8'hF9;
      4'd2:    seg = 8'hA4;
      4'd3:    seg = 8'hB0;
      4'd4:    seg = 8'h99;
      4'd5:    seg = 8'h92;
      4'd6:    seg = 8'h82;
      4'd7:    seg = 8'hF8;
      4'd8:    seg = 8'h80;
      4'd9:    seg = 8'h90;
      default: seg = 8'hFF;
    endcase
    return seg;
  endfunction

endpackage

// ===== rtl/swss_digit_cell.sv =====
`timescale 1ns / 1ps

module swss_digit_cell
  import swss_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctl_t  ctl_i,
  input  logic       carry_i,
  input  logic [3:0] shift_in_i,
  output logic       carry_o,
  output logic [3:0] count_o,
  output logic [3:0] shift_o,
  output logic [3:0] shift_next_o
);

  logic [3:0] cnt_q, cnt_d, cnt_mid;
  logic [3:0] sh_q, sh_d;

  always_comb begin
    cnt_mid = ctl_i.clear ? 4'd0 : cnt_q;
    sh_d    = ctl_i.load ? cnt_mid : shift_in_i;
    carry_o = carry_i && (cnt_mid == DigitMax);
    if (!carry_i) begin
      cnt_d = cnt_mid;
    end else if (cnt_mid == DigitMax) begin
      cnt_d = 4'd0;
    end else begin
      cnt_d = cnt_mid + 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      sh_q  <= '0;
    end else if (ctl_i.en) begin
      cnt_q <= cnt_d;
      sh_q  <= sh_d;
    end
  end

  assign count_o      = cnt_q;
  assign shift_o      = sh_q;
  assign shift_next_o = sh_d;

endmodule

// ===== rtl/stopwatch_seven_segment_scan_unit.sv =====
`timescale 1ns / 1ps
// Channel   | Dir | Handshake                 | Payload (lowest bit first)
// s_axis    | in  | s_axis_tvalid/tready      | now_ms[31:0], left_level, right_level,
//           |     |                           | left_settled, right_settled, pad to 40
// m_axis    | out | m_axis_tvalid/tready      | digit_enable[3:0], segments[11:4]
// apb       | in  | psel & penable & pwrite   | 0x0 lockout, 0x4 count period, 0x8 blink
//
// One scan request per cycle when not stalled; each request updates state when accepted.
// Result leaves from one output register; input is taken whenever that register is empty
// or drained in the same cycle. A request that toggles blink mode yields no result.
// Reset is asynchronous and active low; no clearing pass is needed after reset.

module stopwatch_seven_segment_scan_unit
  import swss_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // now_ms, left_level, right_level, left_settled,
                                      // right_settled, zero pad
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // digit_enable, segments, zero pad
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [CfgW-1:0] lockout_q, count_period_q, blink_period_q;
  reg_idx_e        reg_idx;

  logic             running_q, blink_q, disp_q;
  logic [PosW-1:0]  pos_q;
  logic [TimeW-1:0] last_press_q, last_count_q, last_blink_q;

  logic              out_valid_q;
  logic [NumDigits-1:0] out_en_q;
  logic [SegW-1:0]   out_seg_q;

  logic [TimeW-1:0] now;
  logic             left_level, right_level, left_settled, right_settled;
  logic             fire, lock_ok, left_act, left_blink, right_ok, right_act, right_blink;
  logic             blink_tog, running_mid, disp_mid, count_hit, blink_hit, inc;
  logic [NumDigits-1:0] en_mask;
  cell_ctl_t        ctl;

  logic [3:0] cnt_digit  [NumDigits];
  logic [3:0] sh_digit   [NumDigits];
  logic [3:0] sh_next    [NumDigits];
  logic [3:0] sh_feed    [NumDigits];
  logic       carry      [NumDigits+1];

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[3:2]);

  always_comb begin
    unique case (reg_idx)
      REG_LOCKOUT:      prdata = {16'd0, lockout_q};
      REG_COUNT_PERIOD: prdata = {16'd0, count_period_q};
      REG_BLINK_PERIOD: prdata = {16'd0, blink_period_q};
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lockout_q      <= LockoutRst;
      count_period_q <= CountPeriodRst;
      blink_period_q <= BlinkPeriodRst;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_idx)
        REG_LOCKOUT:      lockout_q      <= pwdata[CfgW-1:0];
        REG_COUNT_PERIOD: count_period_q <= pwdata[CfgW-1:0];
        REG_BLINK_PERIOD: blink_period_q <= pwdata[CfgW-1:0];
        default:          ;
      endcase
    end
  end

  assign now           = s_axis_tdata[31:0];
  assign left_level    = s_axis_tdata[32];
  assign right_level   = s_axis_tdata[33];
  assign left_settled  = s_axis_tdata[34];
  assign right_settled = s_axis_tdata[35];

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign fire          = s_axis_tvalid && s_axis_tready;

  always_comb begin
    lock_ok     = (now - last_press_q) >= {16'd0, lockout_q};
    left_act    = !left_level && lock_ok;
    left_blink  = left_act && right_settled;
    right_ok    = right_level && (left_act ? (lockout_q == '0) : lock_ok);
    right_act   = !left_blink && right_ok;
    right_blink = right_act && !left_settled;
    blink_tog   = left_blink || right_blink;
    running_mid = running_q ^ (left_act && !left_blink);
    disp_mid    = (left_act || right_blink) ? 1'b1 : disp_q;
    count_hit   = (now - last_count_q) >= {16'd0, count_period_q};
    inc         = count_hit && running_mid;
    blink_hit   = !running_mid && blink_q && ((now - last_blink_q) > {16'd0, blink_period_q});
    en_mask     = disp_mid ? ({1'b1, {(NumDigits-1){1'b0}}} >> pos_q) : '0;
    ctl.en      = fire && !blink_tog;
    ctl.clear   = right_act && !right_blink;
    ctl.load    = (pos_q == '0);
  end

  assign carry[0] = inc;

  for (genvar i = 0; i < NumDigits; i++) begin : g_cell
    if (i == NumDigits - 1) begin : g_top
      assign sh_feed[i] = 4'd0;
    end else begin : g_mid
      assign sh_feed[i] = sh_digit[i+1];
    end
    swss_digit_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (ctl),
      .carry_i     (carry[i]),
      .shift_in_i  (sh_feed[i]),
      .carry_o     (carry[i+1]),
      .count_o     (cnt_digit[i]),
      .shift_o     (sh_digit[i]),
      .shift_next_o(sh_next[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q    <= 1'b1;
      blink_q      <= 1'b1;
      disp_q       <= 1'b1;
      pos_q        <= '0;
      last_press_q <= '0;
      last_count_q <= '0;
      last_blink_q <= '0;
    end else if (fire) begin
      running_q <= running_mid;
      if (left_act || right_act) begin
        last_press_q <= now;
      end
      if (blink_tog) begin
        blink_q <= !blink_q;
        disp_q  <= 1'b1;
      end else begin
        disp_q <= blink_hit ? !disp_mid : disp_mid;
        pos_q  <= pos_q + 1'b1;
        if (count_hit) begin
          last_count_q <= now;
        end
        if (blink_hit) begin
          last_blink_q <= now;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire && !blink_tog) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && !blink_tog) begin
      out_en_q  <= en_mask;
      out_seg_q <= seg_lookup(sh_next[0]);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'd0, out_seg_q, out_en_q};

`ifndef SYNTHESIS
  a_enable_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> $onehot0(m_axis_tdata[3:0]))
    else $error("digit enable not one-hot");

  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
    else $error("input taken while result stalled");

  a_digits_decimal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_digit[0] <= DigitMax) && (cnt_digit[1] <= DigitMax) &&
    (cnt_digit[2] <= DigitMax) && (cnt_digit[3] <= DigitMax))
    else $error("count digit out of decimal range");

  a_result_follows_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && !blink_tog) |=> m_axis_tvalid)
    else $error("result missing after scan request");
`endif

endmodule
